[rtl/glzw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// glzw_pkg
// shared types and constants for the gif lzw decoder
// ----------------------------------------------------------------------------
package glzw_pkg;

  localparam int unsigned MaxCodeBits = 12;
  localparam int unsigned StoreDepth  = 1 << MaxCodeBits;
  localparam int unsigned AddrW       = MaxCodeBits;
  localparam int unsigned FillW       = MaxCodeBits + 1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoClear  = 3'd1;
  localparam logic [2:0] StBadCode  = 3'd2;
  localparam logic [2:0] StOverflow = 3'd3;
  localparam logic [2:0] StDropped  = 3'd4;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic CfgMinCodeSize = 1'b0;
  localparam logic CfgFramePixels = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_POP    = 6'b000010,
    S_FIRST  = 6'b000100,
    S_WALK   = 6'b001000,
    S_LAST   = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

endpackage : glzw_pkg
`default_nettype wire

[rtl/gif_lzw_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// variable-width gif lzw decompression with 4096-entry string tables
// ----------------------------------------------------------------------------
// One input beat at a time: a byte beat, or a tick that reads a code without
// expanding it, goes from S_IDLE to S_OUT, a tick that pops one index passes
// through S_POP (stack memory read), and a tick that expands a code passes
// through S_FIRST, S_WALK along its prefix chain, S_LAST and S_OUT, because
// the suffix and prefix tables are walked one entry per cycle through one
// synchronous read port each. A result waiting on the output does not hold off
// the next input beat; the result of that beat waits in the last state until
// the output register frees. The tables and the expansion stack are
// uninitialized memories; only entries written since the last clear are read.
// A configuration write restarts the frame. Every beat yields one result beat.
module gif_lzw_decoder
  import glzw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  wire logic        s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // pixel_index[7:0]
  output logic [5:0]       m_axis_tuser,   // status[2:0], frame_done, need_byte, pixel_valid
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  logic [AddrW-1:0] pre_mem [StoreDepth];
  logic [7:0]       suf_mem [StoreDepth];
  logic [7:0]       fst_mem [StoreDepth];
  logic [7:0]       stk_mem [StoreDepth];

  state_e           state_q, state_d;
  logic [3:0]       mcs_q;
  logic [31:0]      fpix_q;
  logic [FillW-1:0] fill_q;
  logic [31:0]      acc_q;
  logic [5:0]       held_q;
  logic [3:0]       cw_q;
  logic [FillW-1:0] nfc_q;
  logic [AddrW-1:0] prev_q;
  logic             aclr_q, seen_q, eoi_q;
  logic [31:0]      pcnt_q;
  logic [AddrW-1:0] cur_q;      // chain walk cursor
  logic [AddrW-1:0] code_q;     // code being expanded
  logic [FillW-1:0] guard_q;
  logic [7:0]       pre_first_q; // first index of prev code
  logic             knew_q;
  logic             kw_first;
  logic             pv_q;
  logic [7:0]       pix_q;
  logic [2:0]       st_q;
  logic             ovalid_q;
  logic [7:0]       odata_q;
  logic [5:0]       ouser_q;

  // memory read ports
  logic [AddrW-1:0] tab_ra, stk_ra;
  logic [AddrW-1:0] pre_rd;
  logic [7:0]       suf_rd, fst_rd, stk_rd;
  // memory write strobes
  logic             tab_we, stk_we;
  logic [AddrW-1:0] tab_wa, stk_wa;
  logic [AddrW-1:0] tab_wpre;
  logic [7:0]       tab_wsuf, tab_wfst, stk_wd;

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      pre_mem[tab_wa] <= tab_wpre;
      suf_mem[tab_wa] <= tab_wsuf;
      fst_mem[tab_wa] <= tab_wfst;
    end
    pre_rd <= pre_mem[tab_ra];
    suf_rd <= suf_mem[tab_ra];
    fst_rd <= fst_mem[tab_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  logic [FillW-1:0] clr;
  logic [3:0]       cfg_mcs;
  logic [AddrW-1:0] code_mask;
  logic [AddrW-1:0] code;
  logic             in_fire;
  logic             out_hs, out_load;

  assign clr       = FillW'(1) << mcs_q;
  // wraps to all ones at the widest code
  assign code_mask = (AddrW'(1) << cw_q) - AddrW'(1);
  assign code      = acc_q[AddrW-1:0] & code_mask;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_hs    = ovalid_q && m_axis_tready;
  assign out_load  = (state_q == S_OUT) && (!ovalid_q || out_hs);
  assign cfg_mcs   = (cfg_wdata_i[3:0] < 4'd2) ? 4'd2 :
                     (cfg_wdata_i[3:0] > 4'd8) ? 4'd8 : cfg_wdata_i[3:0];

  assign s_axis_tready = (state_q == S_IDLE);

  // kwkwk: the new entry is not written yet, so its first link is forwarded
  assign kw_first = (guard_q == '0) && !knew_q;

  // combinational decode of the code at the head of the accumulator
  logic             is_lit, do_add, do_expand, is_bad;
  logic [FillW-1:0] code_x;
  assign code_x    = {1'b0, code};
  assign is_lit    = code_x < clr;
  assign do_expand = !aclr_q && ((code_x < nfc_q) ||
                     (code_x == nfc_q && nfc_q < FillW'(StoreDepth)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mcs_q <= 4'd8; fpix_q <= 32'd1;
      fill_q <= '0; acc_q <= '0; held_q <= '0; cw_q <= 4'd9;
      nfc_q <= FillW'(258); prev_q <= '0; aclr_q <= 1'b1; seen_q <= 1'b0;
      eoi_q <= 1'b0; pcnt_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= out_load || (ovalid_q && !out_hs);
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgMinCodeSize) begin
          mcs_q <= cfg_mcs; cw_q <= cfg_mcs + 4'd1;
          nfc_q <= (FillW'(1) << cfg_mcs) + FillW'(2);
        end else begin
          fpix_q <= cfg_wdata_i; cw_q <= mcs_q + 4'd1; nfc_q <= clr + FillW'(2);
        end
        fill_q <= '0; acc_q <= '0; held_q <= '0; prev_q <= '0;
        aclr_q <= 1'b1; seen_q <= 1'b0; eoi_q <= 1'b0; pcnt_q <= '0;
      end else begin
        case (state_q)
          S_IDLE: begin
            if (in_fire) begin
              pv_q <= 1'b0; pix_q <= '0; st_q <= StOk;
              if (s_axis_tuser == CmdByte) begin
                if (held_q <= 6'd24) begin
                  acc_q  <= acc_q | (32'(s_axis_tdata) << held_q);
                  held_q <= held_q + 6'd8;
                end else st_q <= StDropped;
              end else if (fill_q != '0) begin
                fill_q <= fill_q - FillW'(1);
              end else if (!eoi_q && held_q >= 6'(cw_q)) begin
                acc_q  <= acc_q >> cw_q;
                held_q <= held_q - 6'(cw_q);
                seen_q <= 1'b1;
                if (!seen_q && code_x != clr) st_q <= StNoClear;
                cur_q <= code; code_q <= code; guard_q <= '0;
                if (code_x == clr) begin
                  cw_q <= mcs_q + 4'd1; nfc_q <= clr + FillW'(2); aclr_q <= 1'b1;
                end else if (code_x == clr + FillW'(1)) begin
                  eoi_q <= 1'b1;
                end else if (aclr_q) begin
                  if (is_lit) begin
                    fill_q <= FillW'(1); prev_q <= code; aclr_q <= 1'b0;
                  end else st_q <= StBadCode;
                end else if (!do_expand) begin
                  st_q <= StBadCode;
                end
              end
            end
          end
          S_POP: begin
            if (pcnt_q < fpix_q) begin
              pv_q <= 1'b1; pix_q <= stk_rd; pcnt_q <= pcnt_q + 32'd1;
            end else st_q <= StOverflow;
          end
          S_FIRST: begin
            // table outputs belong to the prev code here
            pre_first_q <= (prev_q < clr[AddrW-1:0] || clr == FillW'(StoreDepth))
                           ? prev_q[7:0] : fst_rd;
          end
          S_WALK: begin
            if ({1'b0, cur_q} >= clr + FillW'(2) && guard_q < FillW'(StoreDepth)) begin
              if (fill_q < FillW'(StoreDepth)) fill_q <= fill_q + FillW'(1);
              cur_q <= kw_first ? prev_q : pre_rd; guard_q <= guard_q + FillW'(1);
            end else begin
              if (fill_q < FillW'(StoreDepth)) fill_q <= fill_q + FillW'(1);
            end
          end
          S_LAST: begin
            prev_q <= code_q;
          end
          default: ;
        endcase
        if (state_q == S_LAST && nfc_q < FillW'(StoreDepth)) begin
          nfc_q <= nfc_q + FillW'(1);
          if (nfc_q + FillW'(1) == (FillW'(1) << cw_q) && cw_q < 4'(MaxCodeBits))
            cw_q <= cw_q + 4'd1;
        end
      end
    end
  end

  // expansion sequencer: S_FIRST reads first index of prev and the code,
  // S_WALK walks chain; table entry is added once walk ends (S_LAST)
  logic [7:0] kk;
  logic       walk_more;
  logic       pending_expand;
  assign walk_more = ({1'b0, cur_q} >= clr + FillW'(2)) && guard_q < FillW'(StoreDepth);

  assign pending_expand = s_axis_tuser == CmdTick && fill_q == '0 && !eoi_q &&
                          held_q >= 6'(cw_q) && code_x != clr &&
                          code_x != clr + FillW'(1) && !aclr_q && do_expand;

  // first index of new entry: first_of(code) if code < nfc else first_of(prev)
  logic knew;
  assign knew = code_x < nfc_q;
  always_ff @(posedge clk_i) if (state_q == S_IDLE && in_fire) knew_q <= knew;
  logic [7:0] first_code_q;
  // first walk cycle sees the table entry of the code itself
  always_ff @(posedge clk_i)
    if (state_q == S_WALK && guard_q == '0)
      first_code_q <= (cur_q < clr[AddrW-1:0]) ? cur_q[7:0] : fst_rd;
  assign kk = knew_q ? first_code_q : pre_first_q;

  // read address and write controls
  always_comb begin
    state_d = state_q;
    tab_ra  = cur_q;
    stk_ra  = fill_q[AddrW-1:0];
    tab_we  = 1'b0; tab_wa = nfc_q[AddrW-1:0];
    tab_wpre = prev_q; tab_wsuf = kk; tab_wfst = pre_first_q;
    stk_we  = 1'b0; stk_wa = fill_q[AddrW-1:0]; stk_wd = suf_rd;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == CmdTick && fill_q != '0) begin
            stk_ra = fill_q[AddrW-1:0] - AddrW'(1);
            state_d = S_POP;
          end else if (pending_expand) begin
            tab_ra = prev_q; state_d = S_FIRST;
          end else begin
            if (s_axis_tuser == CmdTick && fill_q == '0 && !eoi_q &&
                held_q >= 6'(cw_q) && aclr_q && is_lit && code_x != clr) begin
              stk_we = 1'b1; stk_wa = '0; stk_wd = code[7:0];
            end
            state_d = S_OUT;
          end
        end
      end
      S_POP:   state_d = S_OUT;
      S_FIRST: begin tab_ra = cur_q; state_d = S_WALK; end
      S_WALK: begin
        if (walk_more) begin
          stk_we = fill_q < FillW'(StoreDepth);
          stk_wd = kw_first ? pre_first_q : suf_rd;
          tab_ra = kw_first ? prev_q : pre_rd;
        end else begin
          stk_we = fill_q < FillW'(StoreDepth); stk_wd = cur_q[7:0];
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        tab_we = nfc_q < FillW'(StoreDepth);
        state_d = S_OUT;
      end
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i)
    if (out_load) begin
      odata_q <= pix_q;
      ouser_q <= {st_q, (eoi_q && fill_q == '0), (!eoi_q && held_q < 6'(cw_q)), pv_q};
    end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> ovalid_q)
    else $error("result beat lost under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(StoreDepth))
    else $error("stack fill past depth");

endmodule : gif_lzw_decoder
`default_nettype wire
